// ===== hw/rtl/logic_trace_pixel_decimator_macros.svh =====
// Assertion helpers for the decimator top-level RTL file
`ifndef LOGIC_TRACE_PIXEL_DECIMATOR_MACROS_SVH
`define LOGIC_TRACE_PIXEL_DECIMATOR_MACROS_SVH

// Property checked at every edge outside reset
`define LTPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next
`define LTPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ltpd_pkg.sv =====
package ltpd_pkg;

   localparam int unsigned PIXEL_INDEX_BITS = 12;
   localparam int unsigned CHANNEL_COUNT    = 3;
   localparam int unsigned CHANNEL_SLOTS    = 3;
   localparam int unsigned SPP_BITS         = 18;
   localparam int unsigned SAMPLE_BITS      = 8;

   // Bit positions of the trace channels in a sample byte
   localparam int unsigned CH0_BIT = 0;
   localparam int unsigned CH1_BIT = 1;
   localparam int unsigned CH2_BIT = 4;

   localparam logic [SPP_BITS-1:0]      SPP_RESET     = SPP_BITS'(768);
   localparam logic [CHANNEL_SLOTS-1:0] CH_EN_RESET   = '1;

   typedef enum logic [1:0] {
      PIX_BLANK = 2'd0,
      PIX_LOW   = 2'd1,
      PIX_HIGH  = 2'd2,
      PIX_EDGE  = 2'd3
   } pix_code_type;

   typedef enum logic {
      CSR_SAMPLES_PER_PIXEL = 1'b0,
      CSR_CHANNEL_ENABLE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_byte;
      logic                   capture_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_INDEX_BITS-1:0] pixel_index;
      pix_code_type                trace_ch1;
      pix_code_type                trace_ch2;
      pix_code_type                trace_ch3;
   } rsp_payload_type;

   // Group accumulator to pixel stage
   typedef struct packed {
      logic                     restart;
      logic                     close;
      logic [CHANNEL_SLOTS-1:0] seen_high;
      logic [CHANNEL_SLOTS-1:0] seen_low;
   } grp_info_type;

endpackage

// ===== hw/rtl/ltpd_group.sv =====
module ltpd_group
   import ltpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_payload_type       req,
   input  logic [SPP_BITS-1:0]   samples_per_pixel,
   output grp_info_type          grp
);

   logic [CHANNEL_SLOTS-1:0] and_ff, and_in;
   logic [CHANNEL_SLOTS-1:0] or_ff, or_in;
   logic [SPP_BITS-1:0]      count_ff, count_in;

   logic [CHANNEL_SLOTS-1:0] bits;
   logic [CHANNEL_SLOTS-1:0] and_next;
   logic [CHANNEL_SLOTS-1:0] or_next;
   logic [SPP_BITS-1:0]      count_next;
   logic [SPP_BITS-1:0]      limit;
   logic                     close;

   always_comb begin
      bits = {req.sample_byte[CH2_BIT], req.sample_byte[CH1_BIT], req.sample_byte[CH0_BIT]};
      // A capture start opens a fresh group with this sample as its first
      and_next   = (req.capture_start ? '1 : and_ff) & bits;
      or_next    = (req.capture_start ? '0 : or_ff) | bits;
      count_next = (req.capture_start ? '0 : count_ff) + SPP_BITS'(1);
      limit      = (samples_per_pixel == '0) ? SPP_BITS'(1) : samples_per_pixel;
      close      = (count_next == '0) || (count_next >= limit);

      and_in   = and_ff;
      or_in    = or_ff;
      count_in = count_ff;
      if (fire) begin
         if (close) begin
            and_in   = '1;
            or_in    = '0;
            count_in = '0;
         end else begin
            and_in   = and_next;
            or_in    = or_next;
            count_in = count_next;
         end
      end

      grp.restart   = req.capture_start;
      grp.close     = close;
      grp.seen_high = or_next;
      grp.seen_low  = ~and_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         and_ff   <= '1;
         or_ff    <= '0;
         count_ff <= '0;
      end else begin
         and_ff   <= and_in;
         or_ff    <= or_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/ltpd_pixel.sv =====
module ltpd_pixel
   import ltpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  grp_info_type             grp,
   input  logic [CHANNEL_SLOTS-1:0] channel_enable,
   output rsp_payload_type          pixel
);

   pix_code_type                prev_ff [CHANNEL_SLOTS];
   pix_code_type                prev_in [CHANNEL_SLOTS];
   logic                        first_ff, first_in;
   logic [PIXEL_INDEX_BITS-1:0] index_ff, index_in;

   pix_code_type                prev_base [CHANNEL_SLOTS];
   pix_code_type                draw [CHANNEL_SLOTS];
   pix_code_type                level;
   logic                        first_base;
   logic [PIXEL_INDEX_BITS-1:0] index_base;

   always_comb begin
      first_base = grp.restart | first_ff;
      index_base = grp.restart ? '0 : index_ff;

      first_in = first_ff;
      index_in = index_ff;
      if (fire) begin
         first_in = grp.close ? 1'b0 : first_base;
         index_in = index_base;
         if (grp.close && (index_base != '1)) begin
            index_in = index_base + PIXEL_INDEX_BITS'(1);
         end
      end

      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
         prev_base[i] = grp.restart ? PIX_LOW : prev_ff[i];
         prev_in[i]   = fire ? prev_base[i] : prev_ff[i];
         draw[i]      = PIX_BLANK;
         if (grp.seen_high[i] && grp.seen_low[i]) begin
            level = PIX_EDGE;
         end else if (grp.seen_high[i]) begin
            level = PIX_HIGH;
         end else begin
            level = PIX_LOW;
         end
         if ((i < CHANNEL_COUNT) && channel_enable[i]) begin
            draw[i] = level;
            // A level change against the last settled pixel shows as an edge, unless that pixel was an edge
            if (!first_base && (prev_base[i] != PIX_EDGE) && (prev_base[i] != level)) begin
               draw[i] = PIX_EDGE;
            end
            if (fire && grp.close) begin
               prev_in[i] = level;
            end
         end
      end

      pixel.pixel_index = index_base;
      pixel.trace_ch1   = draw[0];
      pixel.trace_ch2   = draw[1];
      pixel.trace_ch3   = draw[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         index_ff <= '0;
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            prev_ff[i] <= PIX_LOW;
         end
      end else begin
         first_ff <= first_in;
         index_ff <= index_in;
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            prev_ff[i] <= prev_in[i];
         end
      end
   end

endmodule

// ===== hw/rtl/logic_trace_pixel_decimator.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   sample_byte, capture_start
// rsp      out        rsp_valid/rsp_stall   pixel_index, trace_ch1..3
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One sample per cycle unless stalled; rsp shows a pixel the cycle after its group's last sample.
// Group and pixel state update in the cycle of the transfer; the result register is the only stage.
// req_stall rises only while a pixel waits in the result register and rsp_stall is high.
// Synchronous reset restores samples_per_pixel = 768, all channels enabled, an empty group.
`include "logic_trace_pixel_decimator_macros.svh"

module logic_trace_pixel_decimator
   import ltpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [SPP_BITS-1:0]   csr_data
);

   logic [SPP_BITS-1:0]      spp_ff, spp_in;
   logic [CHANNEL_SLOTS-1:0] ch_en_ff, ch_en_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic            req_fire;
   logic            rsp_fire;
   grp_info_type    grp;
   rsp_payload_type pixel;

   assign csr_ready = 1'b1;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   ltpd_group u_group (
      .clock             (clock),
      .reset             (reset),
      .fire              (req_fire),
      .req               (req_payload),
      .samples_per_pixel (spp_ff),
      .grp               (grp)
   );

   ltpd_pixel u_pixel (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .grp            (grp),
      .channel_enable (ch_en_ff),
      .pixel          (pixel)
   );

   always_comb begin
      spp_in   = spp_ff;
      ch_en_in = ch_en_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_PIXEL: spp_in   = csr_data;
            CSR_CHANNEL_ENABLE:    ch_en_in = csr_data[CHANNEL_SLOTS-1:0];
            default:               spp_in   = spp_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && grp.close) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff       <= SPP_RESET;
         ch_en_ff     <= CH_EN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         spp_ff       <= spp_in;
         ch_en_ff     <= ch_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `LTPD_ASSERT(a_stall_only_when_full, !req_stall || rsp_valid_ff, "input stalled with empty result register")
   `LTPD_ASSERT_NEXT(a_restart_index_zero, req_fire && req_payload.capture_start && grp.close, rsp_valid && (rsp_payload.pixel_index == '0), "first pixel of a capture not at index zero")
   `LTPD_ASSERT_NEXT(a_disabled_blank, req_fire && grp.close && !ch_en_ff[0], rsp_payload.trace_ch1 == PIX_BLANK, "disabled channel drew a pixel")
   `LTPD_ASSERT_NEXT(a_no_close_no_new, req_fire && !grp.close && rsp_fire, !rsp_valid, "result appeared without a closed group")

endmodule

// ===== tb/logic_trace_pixel_decimator_tb.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ltpd_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   // Tracks the decimator state and holds the pixels still owed by the block
   class trace_pixel_checker;
      logic [SPP_BITS-1:0]         spp;
      logic [CHANNEL_SLOTS-1:0]    ch_enable;
      logic [CHANNEL_SLOTS-1:0]    and_acc;
      logic [CHANNEL_SLOTS-1:0]    or_acc;
      logic [SPP_BITS-1:0]         grp_count;
      logic [PIXEL_INDEX_BITS-1:0] pixel_count;
      pix_code_type                prev_level[CHANNEL_SLOTS];
      bit                          first_pixel;
      rsp_payload_type             expected_pixels[$];
      int                          fail_count;

      function new();
         spp = SPP_RESET;
         ch_enable = CH_EN_RESET;
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         and_acc = '1;
         or_acc = '0;
         grp_count = '0;
         pixel_count = '0;
         first_pixel = 1'b1;
         foreach (prev_level[ch]) prev_level[ch] = PIX_LOW;
      endfunction

      function void set_register(csr_index_type idx, logic [SPP_BITS-1:0] data);
         case (idx)
            CSR_SAMPLES_PER_PIXEL: spp = data;
            CSR_CHANNEL_ENABLE:    ch_enable = data[CHANNEL_SLOTS-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(req_payload_type p);
         logic [CHANNEL_SLOTS-1:0] ch_bits;
         logic [SPP_BITS-1:0]      group_size;
         pix_code_type             draws[CHANNEL_SLOTS];
         pix_code_type             lvl;
         bit                       hi;
         bit                       lo;
         rsp_payload_type          px;
         if (p.capture_start) restart();
         ch_bits = {p.sample_byte[CH2_BIT], p.sample_byte[CH1_BIT], p.sample_byte[CH0_BIT]};
         and_acc &= ch_bits;
         or_acc |= ch_bits;
         grp_count = grp_count + 1'b1;
         group_size = (spp == '0) ? SPP_BITS'(1) : spp;
         if (grp_count != 0 && grp_count < group_size) return;
         for (int ch = 0; ch < CHANNEL_SLOTS; ch++) begin
            draws[ch] = PIX_BLANK;
            if (ch < CHANNEL_COUNT && ch_enable[ch]) begin
               hi = or_acc[ch];
               lo = !and_acc[ch];
               if (hi && lo) lvl = PIX_EDGE;
               else if (hi) lvl = PIX_HIGH;
               else lvl = PIX_LOW;
               draws[ch] = lvl;
               // a level change across pixels is shown as an edge, unless the last was one
               if (!first_pixel && prev_level[ch] != PIX_EDGE && prev_level[ch] != lvl)
                  draws[ch] = PIX_EDGE;
               prev_level[ch] = lvl;
            end
         end
         px.pixel_index = pixel_count;
         px.trace_ch1 = draws[0];
         px.trace_ch2 = draws[1];
         px.trace_ch3 = draws[2];
         expected_pixels.push_back(px);
         first_pixel = 1'b0;
         if (pixel_count != '1) pixel_count++;
         and_acc = '1;
         or_acc = '0;
         grp_count = '0;
      endfunction

      function void check_pixel(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel with nothing expected: pixel_index %0d", got.pixel_index);
            fail_count++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            fail_count++;
         end
         if (got.trace_ch1 !== want.trace_ch1) begin
            $error("trace_ch1: expected %0d, got %0d", want.trace_ch1, got.trace_ch1);
            fail_count++;
         end
         if (got.trace_ch2 !== want.trace_ch2) begin
            $error("trace_ch2: expected %0d, got %0d", want.trace_ch2, got.trace_ch2);
            fail_count++;
         end
         if (got.trace_ch3 !== want.trace_ch3) begin
            $error("trace_ch3: expected %0d, got %0d", want.trace_ch3, got.trace_ch3);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_SAMPLES_PER_PIXEL;
   logic [SPP_BITS-1:0] csr_data = '0;

   trace_pixel_checker pixel_sb;
   int burst_left = 8;
   int gap_max = 4;
   int random_items = 0;
   int quiet_cycles = 0;
   stall_style_type stall_style = STALL_NONE;
   int style_left = 0;
   int stall_tick = 0;

   logic_trace_pixel_decimator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // receiver stalls in stretches of differing character
   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(16, 256);
      end
      style_left--;
      stall_tick++;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_tick[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) pixel_sb.check_pixel(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("logic_trace_pixel_decimator verification failed");
            $finish;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] b, input logic start);
      req_payload_type p;
      p.sample_byte = b;
      p.capture_start = start;
      req_payload <= p;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixel_sb.note_sample(p);
      @(negedge clock);
      if (gap_max > 0) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // hold off until every owed pixel has been transferred, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pixel_sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [SPP_BITS-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pixel_sb.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [SPP_BITS-1:0] spp, input logic [2:0] chen);
      logic [SPP_BITS-1:0] d;
      drain();
      write_reg(CSR_SAMPLES_PER_PIXEL, spp);
      d = SPP_BITS'($urandom);
      d[2:0] = chen;
      write_reg(CSR_CHANNEL_ENABLE, d);
   endtask

   // channel levels are held for runs so that steady pixels appear as well as edges
   task automatic random_phase(input int n, input int start_odds, input int flip_odds);
      logic [2:0]             held;
      logic [SAMPLE_BITS-1:0] b;
      held = 3'($urandom_range(0, 7));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1, flip_odds) == 1) held = 3'($urandom_range(0, 7));
         b = SAMPLE_BITS'($urandom);
         b[CH0_BIT] = held[0];
         b[CH1_BIT] = held[1];
         b[CH2_BIT] = held[2];
         send_sample(b, start_odds != 0 && $urandom_range(1, start_odds) == 1);
      end
   endtask

   initial begin
      logic [SPP_BITS-1:0] spp;
      int n;
      int flip_odds;
      pixel_sb = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // settings as left by reset
      random_phase(800, 2000, 64);

      gap_max = 0;
      configure(SPP_BITS'(1), 3'b111);
      send_sample(8'h00, 1'b1);
      send_sample(8'hFF, 1'b0);
      send_sample(8'hFF, 1'b0);
      send_sample(8'hEC, 1'b0);
      send_sample(8'h00, 1'b0);
      send_sample(8'h01, 1'b0);
      send_sample(8'h02, 1'b0);
      send_sample(8'h10, 1'b0);
      // zero group size behaves as one
      configure(SPP_BITS'(0), 3'b111);
      send_sample(8'h13, 1'b0);
      send_sample(8'h13, 1'b0);
      configure(SPP_BITS'(1), 3'b000);
      send_sample(8'hFF, 1'b0);
      // middle channel off keeps its stored level
      configure(SPP_BITS'(1), 3'b101);
      send_sample(8'h00, 1'b0);
      send_sample(8'hFF, 1'b0);
      send_sample(8'h00, 1'b0);
      configure(SPP_BITS'(2), 3'b111);
      send_sample(8'h01, 1'b1);
      send_sample(8'h00, 1'b0);
      send_sample(8'h12, 1'b0);
      send_sample(8'h12, 1'b0);
      // shrink the group below the count already reached
      configure(SPP_BITS'(8), 3'b111);
      repeat (5) send_sample(8'h13, 1'b0);
      configure(SPP_BITS'(2), 3'b111);
      send_sample(8'h13, 1'b0);

      while (random_items < 1200) begin
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 16;
         endcase
         case ($urandom_range(0, 4))
            0: spp = SPP_BITS'(0);
            1: spp = SPP_BITS'(1);
            2: spp = SPP_BITS'(2);
            3: spp = SPP_BITS'($urandom_range(3, 12));
            default: spp = SPP_BITS'($urandom_range(13, 40));
         endcase
         case ($urandom_range(0, 2))
            0: flip_odds = 1;
            1: flip_odds = 4;
            default: flip_odds = 32;
         endcase
         configure(spp, 3'($urandom_range(0, 7)));
         n = $urandom_range(30, 200);
         random_phase(n, $urandom_range(20, 400), flip_odds);
         random_items += n;
      end

      drain();
      repeat (16) @(negedge clock);
      if (pixel_sb.fail_count == 0) begin
         $display("logic_trace_pixel_decimator verification clean");
      end else begin
         $display("logic_trace_pixel_decimator verification failed");
      end
      $finish;
   end

endmodule
